@@ rtl/eva_pkg.sv @@
// ----------------------------------------------------------------------------
// eva_pkg
// Shared widths, constants, microcode types and the control store of the
// eased value animator.
// ----------------------------------------------------------------------------
`default_nettype none

package eva_pkg;

  localparam int VALUE_W = 16;
  localparam int TIME_W  = 16;
  localparam int ADV_W   = 8;
  localparam int MODE_W  = 3;
  localparam int PROG_W  = 16;
  localparam int QUOT_W  = 15;
  localparam int CNT_W   = 4;
  localparam int MUL_W   = 18;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FRAC_W  = 15;
  localparam int RND_W   = PROD_W - FRAC_W;
  localparam int VSUM_W  = RND_W + 1;
  localparam int STEP_W  = 5;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [PROG_W-1:0]       Q_ONE     = 16'h8000;
  localparam logic signed [MUL_W-1:0] Q_ONE_M   = 18'sd32768;
  localparam logic signed [MUL_W-1:0] BACK_C1   = 18'sd55757;
  localparam logic signed [MUL_W-1:0] BACK_C3   = 18'sd88525;
  localparam logic [PROD_W-1:0]       RND_HALF  = 36'd16384;
  localparam logic [CNT_W-1:0]        DIV_STEPS = 4'd15;

  localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CIN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUT  = 3'd3;

  localparam logic [1:0] REG_ANIM_MODE   = 2'd0;
  localparam logic [1:0] REG_START_VALUE = 2'd1;
  localparam logic [1:0] REG_END_VALUE   = 2'd2;
  localparam logic [1:0] REG_DURATION    = 2'd3;

  // Control store addresses.
  localparam logic [STEP_W-1:0] S_ENTRY   = 5'd0;
  localparam logic [STEP_W-1:0] S_DIVGO   = 5'd1;
  localparam logic [STEP_W-1:0] S_DIVWAIT = 5'd2;
  localparam logic [STEP_W-1:0] S_LOADT   = 5'd3;
  localparam logic [STEP_W-1:0] S_BACK0   = 5'd4;
  localparam logic [STEP_W-1:0] S_BACK1   = 5'd5;
  localparam logic [STEP_W-1:0] S_BACK2   = 5'd6;
  localparam logic [STEP_W-1:0] S_BACK3   = 5'd7;
  localparam logic [STEP_W-1:0] S_BACK4   = 5'd8;
  localparam logic [STEP_W-1:0] S_BACK5   = 5'd9;
  localparam logic [STEP_W-1:0] S_BACK6   = 5'd10;
  localparam logic [STEP_W-1:0] S_BACK7   = 5'd11;
  localparam logic [STEP_W-1:0] S_CIN0    = 5'd12;
  localparam logic [STEP_W-1:0] S_CIN1    = 5'd13;
  localparam logic [STEP_W-1:0] S_CIN2    = 5'd14;
  localparam logic [STEP_W-1:0] S_CIN3    = 5'd15;
  localparam logic [STEP_W-1:0] S_COUT0   = 5'd16;
  localparam logic [STEP_W-1:0] S_COUT1   = 5'd17;
  localparam logic [STEP_W-1:0] S_COUT2   = 5'd18;
  localparam logic [STEP_W-1:0] S_COUT3   = 5'd19;
  localparam logic [STEP_W-1:0] S_COUT4   = 5'd20;
  localparam logic [STEP_W-1:0] S_LIN     = 5'd21;
  localparam logic [STEP_W-1:0] S_INTERP0 = 5'd22;
  localparam logic [STEP_W-1:0] S_INTERP1 = 5'd23;
  localparam logic [STEP_W-1:0] S_END     = 5'd24;

  typedef enum logic [3:0] {
    ALU_NOP       = 4'd0,
    ALU_ENTRY     = 4'd1,
    ALU_LOAD_T    = 4'd2,
    ALU_F_T_M1    = 4'd3,
    ALU_F_ONE_MT  = 4'd4,
    ALU_F_RND     = 4'd5,
    ALU_F2_RND    = 4'd6,
    ALU_E_ONE_ADD = 4'd7,
    ALU_E_ONE_SUB = 4'd8,
    ALU_E_ADD     = 4'd9,
    ALU_E_RND     = 4'd10,
    ALU_E_T       = 4'd11,
    ALU_VALUE     = 4'd12
  } alu_op_t;

  typedef enum logic [2:0] {
    SEL_T    = 3'd0,
    SEL_F    = 3'd1,
    SEL_F2   = 3'd2,
    SEL_E    = 3'd3,
    SEL_C1   = 3'd4,
    SEL_C3   = 3'd5,
    SEL_DIFF = 3'd6
  } mul_sel_t;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_ENTRY    = 3'd2,
    J_WAIT_DIV = 3'd3,
    J_MODE     = 3'd4,
    J_END      = 3'd5
  } jump_t;

  // Datapath control travelling from the sequencer.
  typedef struct packed {
    alu_op_t  alu;
    logic     mul_en;
    mul_sel_t mul_a;
    mul_sel_t mul_b;
    logic     div_start;
  } ctrl_t;

  // One word of the control store.
  typedef struct packed {
    ctrl_t             ctrl;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic div_busy;
    logic done;
  } status_t;

  function automatic ctrl_t ctrl_nop();
    ctrl_t c;
    c.alu       = ALU_NOP;
    c.mul_en    = 1'b0;
    c.mul_a     = SEL_T;
    c.mul_b     = SEL_T;
    c.div_start = 1'b0;
    return c;
  endfunction

  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w.ctrl   = ctrl_nop();
    w.jump   = J_NEXT;
    w.target = S_END;
    unique case (step)
      S_ENTRY: begin
        w.ctrl.alu = ALU_ENTRY;
        w.jump     = J_ENTRY;
      end
      S_DIVGO:   w.ctrl.div_start = 1'b1;
      S_DIVWAIT: w.jump = J_WAIT_DIV;
      S_LOADT: begin
        w.ctrl.alu = ALU_LOAD_T;
        w.jump     = J_MODE;
      end
      // Back overshoot: 1 + c3*f^3 + c1*f^2 with f = t - 1.
      S_BACK0: w.ctrl.alu = ALU_F_T_M1;
      S_BACK1: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_F;
        w.ctrl.mul_b  = SEL_F;
      end
      S_BACK2: w.ctrl.alu = ALU_F2_RND;
      S_BACK3: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_F2;
        w.ctrl.mul_b  = SEL_F;
      end
      S_BACK4: w.ctrl.alu = ALU_F_RND;
      S_BACK5: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_C3;
        w.ctrl.mul_b  = SEL_F;
      end
      S_BACK6: begin
        w.ctrl.alu    = ALU_E_ONE_ADD;
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_C1;
        w.ctrl.mul_b  = SEL_F2;
      end
      S_BACK7: begin
        w.ctrl.alu = ALU_E_ADD;
        w.jump     = J_GOTO;
        w.target   = S_INTERP0;
      end
      // Cubic in: t^3.
      S_CIN0: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_T;
        w.ctrl.mul_b  = SEL_T;
      end
      S_CIN1: w.ctrl.alu = ALU_F_RND;
      S_CIN2: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_F;
        w.ctrl.mul_b  = SEL_T;
      end
      S_CIN3: begin
        w.ctrl.alu = ALU_E_RND;
        w.jump     = J_GOTO;
        w.target   = S_INTERP0;
      end
      // Cubic out: 1 - (1 - t)^3.
      S_COUT0: w.ctrl.alu = ALU_F_ONE_MT;
      S_COUT1: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_F;
        w.ctrl.mul_b  = SEL_F;
      end
      S_COUT2: w.ctrl.alu = ALU_F2_RND;
      S_COUT3: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_F2;
        w.ctrl.mul_b  = SEL_F;
      end
      S_COUT4: begin
        w.ctrl.alu = ALU_E_ONE_SUB;
        w.jump     = J_GOTO;
        w.target   = S_INTERP0;
      end
      S_LIN: w.ctrl.alu = ALU_E_T;
      S_INTERP0: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_a  = SEL_DIFF;
        w.ctrl.mul_b  = SEL_E;
      end
      S_INTERP1: w.ctrl.alu = ALU_VALUE;
      default:   w.jump = J_END;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/eva_div.sv @@
// ----------------------------------------------------------------------------
// eva_div
// Restoring divider producing the 15-bit fraction (dividend << 15) / divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eva_div
  import eva_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              busy,
  output logic [QUOT_W-1:0] quot
);

  logic [TIME_W:0]   rem_r;
  logic [TIME_W:0]   rem_nxt;
  logic [QUOT_W-1:0] quot_r;
  logic [QUOT_W-1:0] quot_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W:0]   shifted;

  // The partial remainder stays below the divisor, so doubling it fits.
  always_comb begin
    shifted = {rem_r[TIME_W-1:0], 1'b0};
    if (shifted >= {1'b0, divisor}) begin
      rem_nxt  = shifted - {1'b0, divisor};
      quot_nxt = {quot_r[QUOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = shifted;
      quot_nxt = {quot_r[QUOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_STEPS;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = quot_r;

endmodule

`default_nettype wire

@@ rtl/eva_dp.sv @@
// ----------------------------------------------------------------------------
// eva_dp
// Animator datapath: timing state, progress divider, shared rounding
// multiplier, easing registers and the saturating interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module eva_dp
  import eva_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_t                     ctrl,
  input  logic                      req_restart,
  input  logic [ADV_W-1:0]          advance,
  input  logic signed [VALUE_W-1:0] start_value,
  input  logic signed [VALUE_W-1:0] end_value,
  input  logic [TIME_W-1:0]         duration,
  output status_t                   status,
  output logic signed [VALUE_W-1:0] held_value,
  output logic                      finished,
  output logic [PROG_W-1:0]         progress
);

  localparam logic signed [VSUM_W-1:0] VMAX = 22'sd32767;
  localparam logic signed [VSUM_W-1:0] VMIN = -22'sd32768;

  logic [TIME_W-1:0]         elapsed_r;
  logic                      done_r;
  logic signed [VALUE_W-1:0] held_r;
  logic [PROG_W-1:0]         t_r;
  logic                      complete_r;
  logic signed [MUL_W-1:0]   f_r;
  logic signed [MUL_W-1:0]   f2_r;
  logic signed [MUL_W-1:0]   e_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic [TIME_W:0]           el_sum;
  logic [TIME_W-1:0]         el_nxt;
  logic                      complete_now;
  logic                      div_busy;
  logic [QUOT_W-1:0]         quot;
  logic [VALUE_W:0]          diff;
  logic signed [MUL_W-1:0]   opa;
  logic signed [MUL_W-1:0]   opb;
  logic [PROD_W-1:0]         mag;
  logic [PROD_W-1:0]         rsum;
  logic [RND_W-1:0]          rq;
  logic signed [RND_W-1:0]   rnd;
  logic signed [MUL_W-1:0]   rnd_m;
  logic signed [VSUM_W-1:0]  vsum;
  logic signed [VALUE_W-1:0] vsat;

  eva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (elapsed_r),
    .divisor  (duration),
    .busy     (div_busy),
    .quot     (quot)
  );

  // Elapsed time saturates at its all-ones maximum.
  assign el_sum = {1'b0, elapsed_r} + {{(TIME_W + 1 - ADV_W){1'b0}}, advance};
  assign el_nxt = el_sum[TIME_W] ? {TIME_W{1'b1}} : el_sum[TIME_W-1:0];

  assign complete_now = (duration == '0) || (elapsed_r >= duration);

  assign diff = {end_value[VALUE_W-1], end_value} - {start_value[VALUE_W-1], start_value};

  always_comb begin
    case (ctrl.mul_a)
      SEL_T:    opa = $signed({2'b00, t_r});
      SEL_F:    opa = f_r;
      SEL_F2:   opa = f2_r;
      SEL_E:    opa = e_r;
      SEL_C1:   opa = BACK_C1;
      SEL_C3:   opa = BACK_C3;
      SEL_DIFF: opa = $signed({diff[VALUE_W], diff});
      default:  opa = '0;
    endcase
    case (ctrl.mul_b)
      SEL_T:    opb = $signed({2'b00, t_r});
      SEL_F:    opb = f_r;
      SEL_F2:   opb = f2_r;
      SEL_E:    opb = e_r;
      SEL_C1:   opb = BACK_C1;
      SEL_C3:   opb = BACK_C3;
      SEL_DIFF: opb = $signed({diff[VALUE_W], diff});
      default:  opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= opa * opb;
    end
  end

  // Q15 rescale of the product, halves rounded away from zero.
  always_comb begin
    mag   = prod_r[PROD_W-1] ? (~prod_r + 1'b1) : prod_r;
    rsum  = mag + RND_HALF;
    rq    = rsum[PROD_W-1:FRAC_W];
    rnd   = prod_r[PROD_W-1] ? -$signed(rq) : $signed(rq);
    rnd_m = rnd[MUL_W-1:0];
  end

  always_comb begin
    vsum = {{(VSUM_W - VALUE_W){start_value[VALUE_W-1]}}, start_value}
         + {rnd[RND_W-1], rnd};
    if (vsum > VMAX) begin
      vsat = VMAX[VALUE_W-1:0];
    end else if (vsum < VMIN) begin
      vsat = VMIN[VALUE_W-1:0];
    end else begin
      vsat = vsum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      done_r    <= 1'b0;
      held_r    <= '0;
    end else begin
      case (ctrl.alu)
        ALU_ENTRY: begin
          if (req_restart) begin
            elapsed_r <= '0;
            done_r    <= 1'b0;
            held_r    <= start_value;
          end else if (!done_r) begin
            elapsed_r <= el_nxt;
          end
        end
        ALU_VALUE: begin
          held_r <= vsat;
          if (complete_r) begin
            done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.alu)
      ALU_ENTRY: begin
        if (req_restart) begin
          t_r <= '0;
        end else if (done_r) begin
          t_r <= Q_ONE;
        end
      end
      ALU_LOAD_T: begin
        complete_r <= complete_now;
        t_r        <= complete_now ? Q_ONE : {1'b0, quot};
      end
      ALU_F_T_M1:    f_r  <= $signed({2'b00, t_r}) - Q_ONE_M;
      ALU_F_ONE_MT:  f_r  <= Q_ONE_M - $signed({2'b00, t_r});
      ALU_F_RND:     f_r  <= rnd_m;
      ALU_F2_RND:    f2_r <= rnd_m;
      ALU_E_ONE_ADD: e_r  <= Q_ONE_M + rnd_m;
      ALU_E_ONE_SUB: e_r  <= Q_ONE_M - rnd_m;
      ALU_E_ADD:     e_r  <= e_r + rnd_m;
      ALU_E_RND:     e_r  <= rnd_m;
      ALU_E_T:       e_r  <= $signed({2'b00, t_r});
      default: ;
    endcase
  end

  assign status.div_busy = div_busy;
  assign status.done     = done_r;
  assign held_value      = held_r;
  assign finished        = done_r;
  assign progress        = t_r;

endmodule

`default_nettype wire

@@ rtl/eva_seq.sv @@
// ----------------------------------------------------------------------------
// eva_seq
// Microprogram sequencer: step counter, control store lookup and the
// conditional jumps that steer the datapath through one request.
// ----------------------------------------------------------------------------
`default_nettype none

module eva_seq
  import eva_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_restart,
  input  logic [MODE_W-1:0] mode,
  input  status_t           status,
  input  logic              out_free,
  output ctrl_t             ctrl,
  output logic              emit,
  output logic              busy
);

  logic              busy_r;
  logic              busy_nxt;
  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic [STEP_W-1:0] pc_inc;
  logic [STEP_W-1:0] mode_target;
  ucode_t            word;

  assign word   = ucode_word(pc_r);
  assign pc_inc = pc_r + 1'b1;

  always_comb begin
    unique case (mode)
      MODE_NONE: mode_target = S_END;
      MODE_BACK: mode_target = S_BACK0;
      MODE_CIN:  mode_target = S_CIN0;
      MODE_COUT: mode_target = S_COUT0;
      default:   mode_target = S_LIN;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    emit     = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = S_ENTRY;
      end
    end else begin
      case (word.jump)
        J_NEXT:     pc_nxt = pc_inc;
        J_GOTO:     pc_nxt = word.target;
        J_ENTRY:    pc_nxt = (req_restart || status.done) ? S_END : pc_inc;
        J_WAIT_DIV: pc_nxt = status.div_busy ? pc_r : pc_inc;
        J_MODE:     pc_nxt = mode_target;
        J_END: begin
          if (out_free) begin
            emit     = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default:    pc_nxt = S_END;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= S_ENTRY;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctrl = busy_r ? word.ctrl : ctrl_nop();
  assign busy = busy_r;

endmodule

`default_nettype wire

@@ rtl/eased_value_animator_core.sv @@
// ----------------------------------------------------------------------------
// eased_value_animator_core
// Moves one value from a start value to an end value over a programmed
// duration, shaped by a selectable easing curve.
// ----------------------------------------------------------------------------
// Usage. Configure anim_mode, start_value, end_value and duration over the
// APB-style port while the block is idle. Each request on the in_ channel is
// either a restart or a tick that adds in_advance_ms milliseconds; each one
// yields exactly one result on the out_ channel carrying the current value,
// the finished flag and the linear progress in Q1.15.
// Timing. A restart, or a tick after the animation has finished, skips from
// the entry step straight to the end step. An ordinary tick starts the
// progress divider, waits out its 15 quotient steps and then runs the
// microprogram steps of the selected curve. One request is in flight at a
// time; in_stall stays high until its result has been loaded and drops at
// that edge.
// Stalls. The result sits in an output register; a new request is accepted
// while it waits, but its result is held back, with in_stall high, until
// out_stall drops.
// Reset. A synchronous active-low reset clears the timing state, the
// registers (duration returns to 1000 ms) and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_value_animator_core
  import eva_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Request channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [ADV_W-1:0]          in_advance_ms,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value_out,
  output logic                      out_finished,
  output logic [PROG_W-1:0]         out_progress,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam logic [TIME_W-1:0] DURATION_RESET = 16'd1000;

  logic [MODE_W-1:0]         mode_r;
  logic signed [VALUE_W-1:0] start_r;
  logic signed [VALUE_W-1:0] end_r;
  logic [TIME_W-1:0]         dur_r;
  logic                      req_r;
  logic [ADV_W-1:0]          adv_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_finished_r;
  logic [PROG_W-1:0]         out_progress_r;

  logic                      cfg_write;
  logic                      in_accept;
  logic                      out_free;
  logic                      seq_busy;
  logic                      seq_emit;
  ctrl_t                     ctrl;
  status_t                   status;
  logic signed [VALUE_W-1:0] dp_value;
  logic                      dp_finished;
  logic [PROG_W-1:0]         dp_progress;

  // Configuration registers. Writes complete in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      start_r <= '0;
      end_r   <= '0;
      dur_r   <= DURATION_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_ANIM_MODE:   mode_r  <= pwdata[MODE_W-1:0];
        REG_START_VALUE: start_r <= pwdata[VALUE_W-1:0];
        REG_END_VALUE:   end_r   <= pwdata[VALUE_W-1:0];
        REG_DURATION:    dur_r   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ANIM_MODE:   prdata = {{(DATA_W - MODE_W){1'b0}}, mode_r};
      REG_START_VALUE: prdata = {{(DATA_W - VALUE_W){1'b0}}, start_r};
      REG_END_VALUE:   prdata = {{(DATA_W - VALUE_W){1'b0}}, end_r};
      REG_DURATION:    prdata = {{(DATA_W - TIME_W){1'b0}}, dur_r};
      default:         prdata = '0;
    endcase
  end

  // The request is captured on acceptance and held for the whole program.
  assign in_stall  = seq_busy;
  assign in_accept = in_valid && !seq_busy;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_req_type;
      adv_r <= in_advance_ms;
    end
  end

  // The output register can take a new result when it is empty or is being
  // drained in this very cycle.
  assign out_free = !out_valid_r || !out_stall;

  eva_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_accept),
    .req_restart (req_r),
    .mode        (mode_r),
    .status      (status),
    .out_free    (out_free),
    .ctrl        (ctrl),
    .emit        (seq_emit),
    .busy        (seq_busy)
  );

  eva_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .req_restart (req_r),
    .advance     (adv_r),
    .start_value (start_r),
    .end_value   (end_r),
    .duration    (dur_r),
    .status      (status),
    .held_value  (dp_value),
    .finished    (dp_finished),
    .progress    (dp_progress)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_emit) begin
      out_value_r    <= dp_value;
      out_finished_r <= dp_finished;
      out_progress_r <= dp_progress;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_finished  = out_finished_r;
  assign out_progress  = out_progress_r;

endmodule

`default_nettype wire
